// ===== design/mfs_pkg.sv =====
// mfs_pkg: shared widths, register indexes and transaction types
// for the modular feistel s-box pipeline; no dependencies
`default_nettype none

package mfs_pkg;

    localparam int ELEMENT_BITS  = 30;
    localparam int MOD_BITS      = 31;
    localparam int RC_BITS       = 30;
    localparam int RES_BITS      = MOD_BITS;
    localparam int SUM_BITS      = RES_BITS + 1;
    localparam int PROD_BITS     = 2 * SUM_BITS;
    localparam int TOTAL_BITS    = PROD_BITS + 1;
    localparam int RED_STEP      = 4;
    localparam int RED_STAGES    = (TOTAL_BITS + RED_STEP - 1) / RED_STEP;
    localparam int RED_BITS      = RED_STAGES * RED_STEP;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = MOD_BITS;
    localparam int BRANCHES      = 4;

    typedef logic [RES_BITS-1:0] res_t;
    typedef res_t [3:0] win_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MODULUS     = 2'd0,
        REG_ROUND_CONST = 2'd1,
        REG_SQUARE_MODE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [ELEMENT_BITS-1:0] word0;
        logic [ELEMENT_BITS-1:0] word1;
        logic [ELEMENT_BITS-1:0] word2;
        logic [ELEMENT_BITS-1:0] word3;
    } in_item_t;

    typedef struct packed {
        logic [ELEMENT_BITS-1:0] out0;
        logic [ELEMENT_BITS-1:0] out1;
        logic [ELEMENT_BITS-1:0] out2;
        logic [ELEMENT_BITS-1:0] out3;
    } out_item_t;

endpackage

`default_nettype wire

// ===== design/mfs_reduce.sv =====
// mfs_reduce: pipelined remainder unit, a few quotient bits per stage,
// carrying the element window alongside; depends on mfs_pkg
`default_nettype none

module mfs_reduce (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  mfs_pkg::res_t                 p,
    input  logic                          valid_in,
    input  logic [mfs_pkg::TOTAL_BITS-1:0] value,
    input  mfs_pkg::win_t                 win_in,
    output logic                          valid_out,
    output mfs_pkg::res_t                 rem,
    output mfs_pkg::win_t                 win_out
);
    import mfs_pkg::*;

    // one restoring step: shift in a bit, subtract p if it fits
    function automatic res_t red_step(res_t r, logic b, res_t m);
        logic [RES_BITS:0] t;
        t = {r, b};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        return t[RES_BITS-1:0];
    endfunction

    logic                valid_reg [RED_STAGES];
    res_t                rem_reg   [RED_STAGES];
    logic [RED_BITS-1:0] bits_reg  [RED_STAGES];
    win_t                win_reg   [RED_STAGES];

    for (genvar k = 0; k < RED_STAGES; k++)
    begin : g_stage
        logic                s_valid;
        res_t                s_rem;
        logic [RED_BITS-1:0] s_bits;
        win_t                s_win;
        res_t                rem_next;
        logic [RED_BITS-1:0] bits_next;

        if (k == 0)
        begin : g_first
            assign s_valid = valid_in;
            assign s_rem   = '0;
            assign s_bits  = {{(RED_BITS-TOTAL_BITS){1'b0}}, value};
            assign s_win   = win_in;
        end
        else
        begin : g_next
            assign s_valid = valid_reg[k-1];
            assign s_rem   = rem_reg[k-1];
            assign s_bits  = bits_reg[k-1];
            assign s_win   = win_reg[k-1];
        end

        always_comb
        begin
            res_t r;
            r = s_rem;
            for (int j = 0; j < RED_STEP; j++)
            begin
                r = red_step(r, s_bits[RED_BITS-1-j], p);
            end
            rem_next  = r;
            bits_next = s_bits << RED_STEP;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= s_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                bits_reg[k] <= bits_next;
                win_reg[k]  <= s_win;
            end
        end
    end

    assign valid_out = valid_reg[RED_STAGES-1];
    assign rem       = rem_reg[RED_STAGES-1];
    assign win_out   = win_reg[RED_STAGES-1];

endmodule

`default_nettype wire

// ===== design/mfs_branch.sv =====
// mfs_branch: one s-box branch, operand build, multiply, sum and reduce,
// then slides the four-element window; depends on mfs_pkg, mfs_reduce
`default_nettype none

module mfs_branch (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  mfs_pkg::res_t             p,
    input  logic [mfs_pkg::RC_BITS-1:0] c,
    input  logic                      sq,
    input  logic                      valid_in,
    input  mfs_pkg::win_t             win_in,
    output logic                      valid_out,
    output mfs_pkg::win_t             win_out
);
    import mfs_pkg::*;

    localparam int XYC_BITS = SUM_BITS + 1;

    // window (f0,f1,f2,f3): t = f1*f2 (or (f1+f2)^2 in square mode) + f0 + f3 + c mod p, new window (f1,f2,f3,t)
    logic [SUM_BITS-1:0]   sum_ab;
    logic [SUM_BITS-1:0]   op_a_next;
    logic [SUM_BITS-1:0]   op_b_next;
    logic [XYC_BITS-1:0]   xyc_next;
    logic [PROD_BITS-1:0]  prod_next;
    logic [TOTAL_BITS-1:0] total_next;

    logic                  va_reg;
    logic                  vb_reg;
    logic                  vc_reg;
    logic [SUM_BITS-1:0]   op_a_reg;
    logic [SUM_BITS-1:0]   op_b_reg;
    logic [XYC_BITS-1:0]   xyc_a_reg;
    logic [XYC_BITS-1:0]   xyc_b_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    win_t                  win_a_reg;
    win_t                  win_b_reg;
    win_t                  win_c_reg;

    res_t                  red_rem;
    win_t                  red_win;

    always_comb
    begin
        sum_ab     = SUM_BITS'(win_in[1]) + SUM_BITS'(win_in[2]);
        op_a_next  = sq ? sum_ab : SUM_BITS'(win_in[1]);
        op_b_next  = sq ? sum_ab : SUM_BITS'(win_in[2]);
        xyc_next   = XYC_BITS'(win_in[0]) + XYC_BITS'(win_in[3]) + XYC_BITS'(c);
        prod_next  = op_a_reg * op_b_reg;
        total_next = TOTAL_BITS'(prod_reg) + TOTAL_BITS'(xyc_b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= valid_in;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_a_reg  <= op_a_next;
            op_b_reg  <= op_b_next;
            xyc_a_reg <= xyc_next;
            win_a_reg <= win_in;
            prod_reg  <= prod_next;
            xyc_b_reg <= xyc_a_reg;
            win_b_reg <= win_a_reg;
            total_reg <= total_next;
            win_c_reg <= win_b_reg;
        end
    end

    mfs_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .p         (p),
        .valid_in  (vc_reg),
        .value     (total_reg),
        .win_in    (win_c_reg),
        .valid_out (valid_out),
        .rem       (red_rem),
        .win_out   (red_win)
    );

    assign win_out = {red_rem, red_win[3], red_win[2], red_win[1]};

endmodule

`default_nettype wire

// ===== design/modular_feistel_sbox.sv =====
// modular_feistel_sbox: top level, configuration registers, four chained
// s-box branches (two rounds) and an output register with skid stage
// depends on mfs_pkg, mfs_branch
//
//   channel   signals                             width
//   item      item_valid, item_ready, item         4 x 30
//   result    result_valid, result_ready, result   4 x 30
//   config    cfg_we, cfg_index, cfg_data          2 + 31
//
// one group enters per cycle while the skid stage is empty; four branches of
// 3 arithmetic stages plus 17 remainder stages (4 quotient bits each),
// then the output register
// reset clears all valid bits and loads modulus 65537, constant 0, product mode
// the whole pipeline holds only when the skid stage is full
`default_nettype none

module modular_feistel_sbox (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  mfs_pkg::in_item_t                   item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output mfs_pkg::out_item_t                  result,
    input  logic                                cfg_we,
    input  logic [mfs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mfs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import mfs_pkg::*;

    logic [MOD_BITS-1:0] modulus_reg;
    logic [RC_BITS-1:0]  round_const_reg;
    logic                square_mode_reg;
    res_t                p_eff;
    logic                en;

    logic                br_valid [BRANCHES+1];
    win_t                br_win   [BRANCHES+1];
    out_item_t           last_item;

    logic                result_valid_reg;
    logic                result_valid_next;
    out_item_t           result_reg;
    out_item_t           result_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    out_item_t           skid_reg;
    out_item_t           skid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= MOD_BITS'(65537);
            round_const_reg <= '0;
            square_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODULUS:     modulus_reg     <= cfg_data[MOD_BITS-1:0];
                REG_ROUND_CONST: round_const_reg <= cfg_data[RC_BITS-1:0];
                REG_SQUARE_MODE: square_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // a zero modulus behaves as one
    assign p_eff      = (modulus_reg == '0) ? res_t'(1) : modulus_reg;
    assign en         = !skid_valid_reg;
    assign item_ready = en;

    assign br_valid[0] = item_valid;
    assign br_win[0]   = {res_t'(item.word3), res_t'(item.word2),
                          res_t'(item.word1), res_t'(item.word0)};

    for (genvar b = 0; b < BRANCHES; b++)
    begin : g_branch
        mfs_branch u_branch (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .p         (p_eff),
            .c         (round_const_reg),
            .sq        (square_mode_reg),
            .valid_in  (br_valid[b]),
            .win_in    (br_win[b]),
            .valid_out (br_valid[b+1]),
            .win_out   (br_win[b+1])
        );
    end

    // after two rounds the window is (t1, t2) of round one then (t3, t4) of round two
    assign last_item.out0 = br_win[BRANCHES][0][ELEMENT_BITS-1:0];
    assign last_item.out1 = br_win[BRANCHES][1][ELEMENT_BITS-1:0];
    assign last_item.out2 = br_win[BRANCHES][2][ELEMENT_BITS-1:0];
    assign last_item.out3 = br_win[BRANCHES][3][ELEMENT_BITS-1:0];

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        skid_valid_next   = skid_valid_reg;
        skid_next         = skid_reg;
        if (skid_valid_reg)
        begin
            if (result_ready)
            begin
                result_next     = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (br_valid[BRANCHES])
        begin
            if (!result_valid_reg || result_ready)
            begin
                result_valid_next = 1'b1;
                result_next       = last_item;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = last_item;
            end
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        skid_reg   <= skid_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    a_skid_behind_result: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid holds a transaction while the output register is empty");

    a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready && !skid_valid_reg && br_valid[BRANCHES])
        |=> skid_valid_reg)
        else $error("finished transaction not caught by the skid stage");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && result_ready) |=> (result_valid_reg && !skid_valid_reg))
        else $error("skid stage did not drain into the output register");

    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        br_valid[BRANCHES] |-> (br_win[BRANCHES][3] < p_eff))
        else $error("final residue not below the modulus");
`endif

endmodule

`default_nettype wire
